// ===== src/psht_pkg.sv =====
// psht_pkg: shared types, codes and helpers of the packet statistics host table
// no dependencies; imported by every module of the block but psht_ram
`default_nettype none
package psht_pkg;

  localparam logic [7:0] PROTO_ICMP = 8'h01;
  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam logic [7:0] PROTO_UDP  = 8'h11;

  localparam logic [1:0] PCLS_OTHER = 2'd0;
  localparam logic [1:0] PCLS_ICMP  = 2'd1;
  localparam logic [1:0] PCLS_TCP   = 2'd2;
  localparam logic [1:0] PCLS_UDP   = 2'd3;

  localparam logic [2:0] APP_NONE = 3'd0;
  localparam logic [2:0] APP_FTP  = 3'd1;
  localparam logic [2:0] APP_SSH  = 3'd2;
  localparam logic [2:0] APP_DNS  = 3'd3;
  localparam logic [2:0] APP_HTTP = 3'd4;

  localparam logic [1:0] REG_FTP  = 2'd0;
  localparam logic [1:0] REG_SSH  = 2'd1;
  localparam logic [1:0] REG_DNS  = 2'd2;
  localparam logic [1:0] REG_HTTP = 2'd3;

  localparam logic [15:0] FTP_PORT_RST  = 16'd21;
  localparam logic [15:0] SSH_PORT_RST  = 16'd22;
  localparam logic [15:0] DNS_PORT_RST  = 16'd53;
  localparam logic [15:0] HTTP_PORT_RST = 16'd80;

  localparam int QUEUE_DEPTH = 2;

  typedef logic [3:0][15:0] psht_ports_t;

  // one request as the front hands it to the back
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] len;
    logic [31:0] pkt_total;
    logic [31:0] byte_total;
    logic [1:0]  pclass;
    logic [31:0] pcount;
    logic [2:0]  aclass;
    logic [31:0] acount;
    logic [39:0] elapsed;
  } psht_item_t;

  typedef struct packed {
    logic [5:0]  host_slot;
    logic        new_host;
    logic        table_full;
    logic [31:0] host_packets;
    logic [31:0] host_bytes;
    psht_item_t  item;
  } psht_result_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } psht_bk_state_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/psht_ram.sv =====
// psht_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module psht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== src/psht_front.sv =====
// psht_front: takes a request, classifies protocol and port class, keeps the
// global counters and first timestamp; depends on psht_pkg
`default_nettype none
module psht_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psht_pkg::psht_ports_t ports,
  input  wire logic                 accept,
  input  wire logic [31:0]          dst_ip,
  input  wire logic [15:0]          packet_length,
  input  wire logic [7:0]           ip_protocol,
  input  wire logic [15:0]          source_port,
  input  wire logic [15:0]          dst_port,
  input  wire logic [39:0]          timestamp_us,
  output psht_pkg::psht_item_t      item
);
  import psht_pkg::*;

  logic [31:0]       pkts_r, pkts_nxt;
  logic [31:0]       bytes_r, bytes_nxt;
  logic [31:0]       icmp_r, icmp_nxt;
  logic [31:0]       tcp_r, tcp_nxt;
  logic [31:0]       udp_r, udp_nxt;
  logic [3:0][31:0]  app_r, app_nxt;
  logic [39:0]       first_r, first_nxt;
  logic [3:0]        hit;
  logic [39:0]       base;

  always_comb begin
    pkts_nxt  = sat_add32(pkts_r, 32'd1);
    bytes_nxt = sat_add32(bytes_r, {16'd0, packet_length});
    icmp_nxt  = icmp_r;
    tcp_nxt   = tcp_r;
    udp_nxt   = udp_r;
    app_nxt   = app_r;
    first_nxt = (pkts_r == 32'd0) ? timestamp_us : first_r;
    base      = first_nxt;

    for (int i = 0; i < 4; i++) begin
      hit[i] = (source_port == ports[i]) || (dst_port == ports[i]);
    end

    item.ip         = dst_ip;
    item.len        = packet_length;
    item.pkt_total  = pkts_nxt;
    item.byte_total = bytes_nxt;
    item.elapsed    = timestamp_us - base;

    case (ip_protocol)
      PROTO_ICMP: begin
        icmp_nxt    = sat_add32(icmp_r, 32'd1);
        item.pclass = PCLS_ICMP;
        item.pcount = icmp_nxt;
      end
      PROTO_TCP: begin
        tcp_nxt     = sat_add32(tcp_r, 32'd1);
        item.pclass = PCLS_TCP;
        item.pcount = tcp_nxt;
      end
      PROTO_UDP: begin
        udp_nxt     = sat_add32(udp_r, 32'd1);
        item.pclass = PCLS_UDP;
        item.pcount = udp_nxt;
      end
      default: begin
        item.pclass = PCLS_OTHER;
        item.pcount = 32'd0;
      end
    endcase

    // first matching class wins
    if (hit[REG_FTP]) begin
      app_nxt[REG_FTP] = sat_add32(app_r[REG_FTP], 32'd1);
      item.aclass      = APP_FTP;
      item.acount      = app_nxt[REG_FTP];
    end else if (hit[REG_SSH]) begin
      app_nxt[REG_SSH] = sat_add32(app_r[REG_SSH], 32'd1);
      item.aclass      = APP_SSH;
      item.acount      = app_nxt[REG_SSH];
    end else if (hit[REG_DNS]) begin
      app_nxt[REG_DNS] = sat_add32(app_r[REG_DNS], 32'd1);
      item.aclass      = APP_DNS;
      item.acount      = app_nxt[REG_DNS];
    end else if (hit[REG_HTTP]) begin
      app_nxt[REG_HTTP] = sat_add32(app_r[REG_HTTP], 32'd1);
      item.aclass       = APP_HTTP;
      item.acount       = app_nxt[REG_HTTP];
    end else begin
      item.aclass = APP_NONE;
      item.acount = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkts_r  <= '0;
      bytes_r <= '0;
      icmp_r  <= '0;
      tcp_r   <= '0;
      udp_r   <= '0;
      app_r   <= '0;
      first_r <= '0;
    end else if (accept) begin
      pkts_r  <= pkts_nxt;
      bytes_r <= bytes_nxt;
      icmp_r  <= icmp_nxt;
      tcp_r   <= tcp_nxt;
      udp_r   <= udp_nxt;
      app_r   <= app_nxt;
      first_r <= first_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/psht_queue.sv =====
// psht_queue: short request queue between the front and the table back end
// depends on psht_pkg
`default_nettype none
module psht_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire psht_pkg::psht_item_t wr_item,
  input  wire logic                pop,
  output psht_pkg::psht_item_t     rd_item,
  output logic                     empty,
  output logic                     full
);
  import psht_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  psht_item_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    empty      = (cnt_r == NW'(0));
    full       = (cnt_r == NW'(QUEUE_DEPTH));
    rd_item    = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/psht_back.sv =====
// psht_back: host table sequencer; searches the address RAM one entry a cycle,
// updates or appends host counters or flags full table; uses psht_pkg, psht_ram
`default_nettype none
module psht_back #(
  parameter int HOST_ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire psht_pkg::psht_item_t q_item,
  output logic                      q_pop,
  output logic                      res_valid,
  output psht_pkg::psht_result_t    res
);
  import psht_pkg::*;

  localparam int AW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
  localparam int CW = $clog2(HOST_ENTRIES + 1);
  localparam int SW = (AW > 6) ? AW : 6;

  psht_bk_state_t  state_r, state_nxt;
  psht_item_t      item_r, item_nxt;
  logic [CW-1:0]   issue_r, issue_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic            res_valid_r, res_valid_nxt;
  psht_result_t    res_r, res_nxt;

  logic            issuing;
  logic            match;
  logic            addr_we;
  logic            cnt_we;
  logic [AW-1:0]   wr_addr;
  logic [63:0]     cnt_wdata;
  logic [31:0]     addr_rdata;
  logic [63:0]     cnt_rdata;
  logic [SW-1:0]   slot_ext;

  psht_ram #(.WIDTH(32), .DEPTH(HOST_ENTRIES)) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (wr_addr),
    .wdata (item_r.ip),
    .raddr (issue_r[AW-1:0]),
    .rdata (addr_rdata)
  );

  // packet count in the upper half, byte count in the lower
  psht_ram #(.WIDTH(64), .DEPTH(HOST_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .raddr (issue_r[AW-1:0]),
    .rdata (cnt_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    issue_nxt     = issue_r;
    used_nxt      = used_r;
    rd_vld_nxt    = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    addr_we       = 1'b0;
    cnt_we        = 1'b0;
    wr_addr       = cmp_idx_r;
    cnt_wdata     = '0;
    slot_ext      = '0;
    issuing       = (state_r == BK_SCAN) && (issue_r < used_r);
    match         = rd_vld_r && (addr_rdata == item_r.ip);

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          issue_nxt = '0;
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        // read of the next entry overlaps the compare of the previous one
        rd_vld_nxt  = issuing;
        cmp_idx_nxt = issue_r[AW-1:0];
        issue_nxt   = issue_r + CW'(issuing);
        res_nxt.item = item_r;
        if (match) begin
          cnt_we    = 1'b1;
          wr_addr   = cmp_idx_r;
          cnt_wdata = {sat_add32(cnt_rdata[63:32], 32'd1),
                       sat_add32(cnt_rdata[31:0], {16'd0, item_r.len})};
          slot_ext  = SW'(cmp_idx_r);
          res_nxt.host_slot    = slot_ext[5:0];
          res_nxt.new_host     = 1'b0;
          res_nxt.table_full   = 1'b0;
          res_nxt.host_packets = cnt_wdata[63:32];
          res_nxt.host_bytes   = cnt_wdata[31:0];
          res_valid_nxt = 1'b1;
          rd_vld_nxt    = 1'b0;
          state_nxt     = BK_IDLE;
        end else if (!issuing) begin
          if (used_r < CW'(HOST_ENTRIES)) begin
            addr_we   = 1'b1;
            cnt_we    = 1'b1;
            wr_addr   = used_r[AW-1:0];
            cnt_wdata = {32'd1, 16'd0, item_r.len};
            used_nxt  = used_r + CW'(1);
            slot_ext  = SW'(used_r[AW-1:0]);
            res_nxt.host_slot    = slot_ext[5:0];
            res_nxt.new_host     = 1'b1;
            res_nxt.table_full   = 1'b0;
            res_nxt.host_packets = 32'd1;
            res_nxt.host_bytes   = {16'd0, item_r.len};
          end else begin
            res_nxt.host_slot    = '0;
            res_nxt.new_host     = 1'b0;
            res_nxt.table_full   = 1'b1;
            res_nxt.host_packets = '0;
            res_nxt.host_bytes   = '0;
          end
          res_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      issue_r     <= '0;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== src/packet_statistics_host_table_core.sv =====
// packet_statistics_host_table_core: top level of the per-destination packet
// statistics block; depends on psht_pkg, psht_front, psht_queue, psht_back
//
// A request (one parsed header) is taken on in_* when start is high and busy
// is low. The front classifies it by protocol and by port (ftp, ssh, dns, http
// registers on the apb port, byte address 4*i) and updates the totals, class
// counters and first timestamp at once; it then waits in a two-entry queue.
// The back searches the host table RAM one entry per cycle, then updates or
// appends the entry, or flags a full table.
// Per request the back takes the request from the queue, then reads and compares
// each stored host in turn, ending with a last compare; a hit stops the search at
// that slot. busy is high while the queue is full. Each result sits on out_* for
// one cycle with out_valid high; the receiver cannot stall, so no result is ever
// held back. Reset clears the counters, the host count and the queue and restores
// the default port registers; host table RAM contents need no clearing.
`default_nettype none
module packet_statistics_host_table_core #(
  parameter int HOST_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [7:0]  in_ip_protocol,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [39:0] in_timestamp_us,
  output logic             out_valid,
  output logic [5:0]       out_host_slot,
  output logic             out_new_host,
  output logic             out_table_full,
  output logic [31:0]      out_host_packets,
  output logic [31:0]      out_host_bytes,
  output logic [31:0]      out_pkt_total,
  output logic [31:0]      out_byte_total,
  output logic [1:0]       out_protocol_class,
  output logic [31:0]      out_protocol_count,
  output logic [2:0]       out_app_class,
  output logic [31:0]      out_app_count,
  output logic [39:0]      out_elapsed_us,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import psht_pkg::*;

  psht_ports_t  ports_r;
  logic         accept;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  psht_item_t   front_item;
  psht_item_t   q_item;
  psht_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r[REG_FTP]  <= FTP_PORT_RST;
      ports_r[REG_SSH]  <= SSH_PORT_RST;
      ports_r[REG_DNS]  <= DNS_PORT_RST;
      ports_r[REG_HTTP] <= HTTP_PORT_RST;
    end else if (psel && penable && pwrite && pready) begin
      ports_r[paddr[3:2]] <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {16'd0, ports_r[paddr[3:2]]};

  assign busy   = q_full;
  assign accept = start && !busy;

  psht_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .ports         (ports_r),
    .accept        (accept),
    .dst_ip        (in_dst_ip),
    .packet_length (in_packet_length),
    .ip_protocol   (in_ip_protocol),
    .source_port   (in_source_port),
    .dst_port      (in_dst_port),
    .timestamp_us  (in_timestamp_us),
    .item          (front_item)
  );

  psht_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .wr_item (front_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  psht_back #(.HOST_ENTRIES(HOST_ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_host_slot      = res.host_slot;
  assign out_new_host       = res.new_host;
  assign out_table_full     = res.table_full;
  assign out_host_packets   = res.host_packets;
  assign out_host_bytes     = res.host_bytes;
  assign out_pkt_total      = res.item.pkt_total;
  assign out_byte_total     = res.item.byte_total;
  assign out_protocol_class = res.item.pclass;
  assign out_protocol_count = res.item.pcount;
  assign out_app_class      = res.item.aclass;
  assign out_app_count      = res.item.acount;
  assign out_elapsed_us     = res.item.elapsed;

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_host && out_table_full))
    else $error("result marked both new host and table full");

  a_full_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_host_packets == 32'd0 && out_host_slot == 6'd0)
    else $error("full-table result carries host data");

  a_new_first_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_host |-> out_host_packets == 32'd1)
    else $error("new host result without a packet count of one");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back end produced results on adjacent cycles");

endmodule
`default_nettype wire

// ===== test/tb_packet_statistics_host_table_core.sv =====
// tb_packet_statistics_host_table_core: self-checking bench for the packet statistics host table
// needs psht_pkg and packet_statistics_host_table_core; directed headers first, then random
// traffic over several port settings and sender gap rates, each result checked against a predictor or its typed row
module tb_packet_statistics_host_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import psht_pkg::*;

  localparam int HOSTS = 64;

  typedef struct packed {
    logic [31:0] dst_ip;
    logic [15:0] len;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [39:0] ts;
  } header_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        new_host;
    logic        full;
    logic [31:0] host_pkts;
    logic [31:0] host_bytes;
    logic [31:0] tot_pkts;
    logic [31:0] tot_bytes;
    logic [1:0]  pcls;
    logic [31:0] pcnt;
    logic [2:0]  acls;
    logic [31:0] acnt;
    logic [39:0] elapsed;
  } report_t;

  typedef struct {
    header_t hdr;
    bit      typed;
    report_t want;
  } row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_dst_ip = '0;
  logic [15:0] in_packet_length = '0;
  logic [7:0]  in_ip_protocol = '0;
  logic [15:0] in_source_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [39:0] in_timestamp_us = '0;
  logic        out_valid;
  logic [5:0]  out_host_slot;
  logic        out_new_host;
  logic        out_table_full;
  logic [31:0] out_host_packets;
  logic [31:0] out_host_bytes;
  logic [31:0] out_pkt_total;
  logic [31:0] out_byte_total;
  logic [1:0]  out_protocol_class;
  logic [31:0] out_protocol_count;
  logic [2:0]  out_app_class;
  logic [31:0] out_app_count;
  logic [39:0] out_elapsed_us;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [31:0] tab_ip [HOSTS];
  logic [31:0] tab_pkts [HOSTS];
  logic [31:0] tab_bytes [HOSTS];
  int          tab_used;
  logic [31:0] seen_pkts;
  logic [31:0] seen_bytes;
  logic [31:0] proto_tally [4];
  logic [31:0] app_tally [4];
  logic [39:0] first_ts;
  logic [15:0] port_cfg [4];
  logic [39:0] clock_us;

  report_t     due_reports [$];
  int          failures = 0;

  packet_statistics_host_table_core #(.HOST_ENTRIES(HOSTS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_dst_ip(in_dst_ip),
    .in_packet_length(in_packet_length),
    .in_ip_protocol(in_ip_protocol),
    .in_source_port(in_source_port),
    .in_dst_port(in_dst_port),
    .in_timestamp_us(in_timestamp_us),
    .out_valid(out_valid),
    .out_host_slot(out_host_slot),
    .out_new_host(out_new_host),
    .out_table_full(out_table_full),
    .out_host_packets(out_host_packets),
    .out_host_bytes(out_host_bytes),
    .out_pkt_total(out_pkt_total),
    .out_byte_total(out_byte_total),
    .out_protocol_class(out_protocol_class),
    .out_protocol_count(out_protocol_count),
    .out_app_class(out_app_class),
    .out_app_count(out_app_count),
    .out_elapsed_us(out_elapsed_us),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_counts();
    tab_used = 0;
    seen_pkts = '0;
    seen_bytes = '0;
    proto_tally = '{default: '0};
    app_tally = '{default: '0};
    first_ts = '0;
    clock_us = '0;
    port_cfg[REG_FTP] = FTP_PORT_RST;
    port_cfg[REG_SSH] = SSH_PORT_RST;
    port_cfg[REG_DNS] = DNS_PORT_RST;
    port_cfg[REG_HTTP] = HTTP_PORT_RST;
  endfunction

  // updates the counters and host table for one header, returns what the block should report
  function automatic report_t tally_header(header_t h);
    report_t r;
    int      hit;
    int      i;
    r = '0;
    hit = -1;
    if (seen_pkts == 0) first_ts = h.ts;
    seen_pkts = sat_inc(seen_pkts, 1);
    seen_bytes = sat_inc(seen_bytes, 32'(h.len));
    r.tot_pkts = seen_pkts;
    r.tot_bytes = seen_bytes;
    case (h.proto)
      PROTO_ICMP: r.pcls = PCLS_ICMP;
      PROTO_TCP:  r.pcls = PCLS_TCP;
      PROTO_UDP:  r.pcls = PCLS_UDP;
      default:    r.pcls = PCLS_OTHER;
    endcase
    if (r.pcls != PCLS_OTHER) begin
      proto_tally[r.pcls] = sat_inc(proto_tally[r.pcls], 1);
      r.pcnt = proto_tally[r.pcls];
    end
    // first matching port class wins, either direction
    for (i = 0; i < 4; i++) begin
      if (r.acls == APP_NONE && (h.sport == port_cfg[i] || h.dport == port_cfg[i])) begin
        app_tally[i] = sat_inc(app_tally[i], 1);
        r.acls = APP_FTP + 3'(i);
        r.acnt = app_tally[i];
      end
    end
    for (i = 0; i < tab_used; i++) begin
      if (hit < 0 && tab_ip[i] == h.dst_ip) hit = i;
    end
    if (hit >= 0) begin
      tab_pkts[hit] = sat_inc(tab_pkts[hit], 1);
      tab_bytes[hit] = sat_inc(tab_bytes[hit], 32'(h.len));
      r.slot = 6'(hit);
      r.host_pkts = tab_pkts[hit];
      r.host_bytes = tab_bytes[hit];
    end else if (tab_used < HOSTS) begin
      tab_ip[tab_used] = h.dst_ip;
      tab_pkts[tab_used] = 32'd1;
      tab_bytes[tab_used] = 32'(h.len);
      r.slot = 6'(tab_used);
      r.new_host = 1'b1;
      r.host_pkts = 32'd1;
      r.host_bytes = 32'(h.len);
      tab_used++;
    end else begin
      r.full = 1'b1;
    end
    r.elapsed = h.ts - first_ts;
    return r;
  endfunction

  function automatic header_t hdr(logic [31:0] ip, logic [15:0] len, logic [7:0] proto,
                                  logic [15:0] sp, logic [15:0] dp, logic [39:0] ts);
    return {ip, len, proto, sp, dp, ts};
  endfunction

  function automatic report_t rep(logic [5:0] slot, logic nh, logic full, logic [31:0] hp,
                                  logic [31:0] hb, logic [31:0] tp, logic [31:0] tb,
                                  logic [1:0] pc, logic [31:0] pn, logic [2:0] ac,
                                  logic [31:0] an, logic [39:0] el);
    return {slot, nh, full, hp, hb, tp, tb, pc, pn, ac, an, el};
  endfunction

  // mostly known hosts and configured ports, with fresh hosts that end up filling the table
  function automatic header_t random_header();
    header_t h;
    int      pick;
    pick = $urandom_range(99);
    if (tab_used != 0 && pick < 70) h.dst_ip = tab_ip[$urandom_range(tab_used - 1)];
    else h.dst_ip = $urandom();
    pick = $urandom_range(9);
    h.len = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 30) h.proto = PROTO_TCP;
    else if (pick < 55) h.proto = PROTO_UDP;
    else if (pick < 70) h.proto = PROTO_ICMP;
    else h.proto = 8'($urandom());
    h.sport = ($urandom_range(99) < 40) ? port_cfg[$urandom_range(3)] : 16'($urandom());
    h.dport = ($urandom_range(99) < 40) ? port_cfg[$urandom_range(3)] : 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 4) clock_us = 40'({$urandom(), $urandom()});
    else if (pick < 6) clock_us = 40'hFF_FFFF_FFFF - 40'($urandom_range(3000000));
    else clock_us = clock_us + 40'($urandom_range(2000000));
    h.ts = clock_us;
    return h;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
    if (got !== want) note_failure($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endtask

  task automatic compare_report(report_t want, report_t got);
    check_field("host_slot", 40'(want.slot), 40'(got.slot));
    check_field("new_host", 40'(want.new_host), 40'(got.new_host));
    check_field("table_full", 40'(want.full), 40'(got.full));
    check_field("host_packets", 40'(want.host_pkts), 40'(got.host_pkts));
    check_field("host_bytes", 40'(want.host_bytes), 40'(got.host_bytes));
    check_field("pkt_total", 40'(want.tot_pkts), 40'(got.tot_pkts));
    check_field("byte_total", 40'(want.tot_bytes), 40'(got.tot_bytes));
    check_field("protocol_class", 40'(want.pcls), 40'(got.pcls));
    check_field("protocol_count", 40'(want.pcnt), 40'(got.pcnt));
    check_field("app_class", 40'(want.acls), 40'(got.acls));
    check_field("app_count", 40'(want.acnt), 40'(got.acnt));
    check_field("elapsed_us", want.elapsed, got.elapsed);
  endtask

  // start is left high on return so back-to-back requests need no extra edge
  task automatic send_header(header_t h, int idle_pct, bit typed, report_t want);
    report_t model;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_dst_ip <= h.dst_ip;
    in_packet_length <= h.len;
    in_ip_protocol <= h.proto;
    in_source_port <= h.sport;
    in_dst_port <= h.dport;
    in_timestamp_us <= h.ts;
    do @(posedge clk); while (busy);
    model = tally_header(h);
    due_reports.push_back(typed ? want : model);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // dropping psel after each write keeps consecutive writes apart
  task automatic write_port(logic [1:0] idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    port_cfg[idx] = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] ftp, logic [15:0] ssh, logic [15:0] dns,
                           logic [15:0] http, int idle_pct, int count);
    int n;
    wait_drained();
    write_port(REG_FTP, ftp);
    write_port(REG_SSH, ssh);
    write_port(REG_DNS, dns);
    write_port(REG_HTTP, http);
    for (n = 0; n < count; n++) begin
      if (n % 97 == 96) wait_drained();
      send_header(random_header(), idle_pct, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    report_t got;
    report_t want;
    if (rst_n && out_valid) begin
      got = {out_host_slot, out_new_host, out_table_full, out_host_packets, out_host_bytes,
             out_pkt_total, out_byte_total, out_protocol_class, out_protocol_count,
             out_app_class, out_app_count, out_elapsed_us};
      if (due_reports.size() == 0) begin
        note_failure($sformatf("result with no request waiting, packet total %0d",
                               got.tot_pkts));
      end else begin
        want = due_reports.pop_front();
        compare_report(want, got);
      end
    end
  end

  initial begin : stimulus
    row_t rows [$];
    clear_counts();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // first packet sets the reference time, so elapsed starts at zero
    rows.push_back('{hdr(32'h0, 16'd0, PROTO_ICMP, FTP_PORT_RST, 16'd0, 40'd1000), 1'b1,
                     rep(6'd0, 1'b1, 1'b0, 32'd1, 32'd0, 32'd1, 32'd0, PCLS_ICMP, 32'd1,
                         APP_FTP, 32'd1, 40'd0)});
    rows.push_back('{hdr(32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP, 16'd0, SSH_PORT_RST,
                         40'd1001000), 1'b1,
                     rep(6'd1, 1'b1, 1'b0, 32'd1, 32'd65535, 32'd2, 32'd65535, PCLS_TCP,
                         32'd1, APP_SSH, 32'd1, 40'd1000000)});
    // timestamp earlier than the first one wraps
    rows.push_back('{hdr(32'h0, 16'd100, PROTO_UDP, DNS_PORT_RST, DNS_PORT_RST, 40'd0), 1'b1,
                     rep(6'd0, 1'b0, 1'b0, 32'd2, 32'd100, 32'd3, 32'd65635, PCLS_UDP, 32'd1,
                         APP_DNS, 32'd1, 40'hFF_FFFF_FC18)});
    rows.push_back('{hdr(32'hFFFF_FFFF, 16'd1, 8'hFF, HTTP_PORT_RST, 16'hFFFF,
                         40'hFF_FFFF_FFFF), 1'b1,
                     rep(6'd1, 1'b0, 1'b0, 32'd2, 32'd65536, 32'd4, 32'd65636, PCLS_OTHER,
                         32'd0, APP_HTTP, 32'd1, 40'hFF_FFFF_FC17)});
    // http on one side, ftp on the other: ftp is checked first
    rows.push_back('{hdr(32'h0A00_0001, 16'd64, 8'h00, HTTP_PORT_RST, FTP_PORT_RST, 40'd2000),
                     1'b1,
                     rep(6'd2, 1'b1, 1'b0, 32'd1, 32'd64, 32'd5, 32'd65700, PCLS_OTHER,
                         32'd0, APP_FTP, 32'd2, 40'd1000)});
    rows.push_back('{hdr(32'h0A00_0001, 16'd1500, 8'h02, SSH_PORT_RST, DNS_PORT_RST,
                         40'd2500), 1'b0, '0});
    rows.push_back('{hdr(32'h0A00_0002, 16'd40, 8'h07, 16'd1024, HTTP_PORT_RST, 40'd3000),
                     1'b0, '0});
    rows.push_back('{hdr(32'h0A00_0001, 16'd576, 8'h10, 16'hFFFF, 16'hFFFF, 40'd3000), 1'b0,
                     '0});
    rows.push_back('{hdr(32'h0A00_0003, 16'd9000, 8'h12, DNS_PORT_RST, FTP_PORT_RST,
                         40'd3500), 1'b0, '0});
    rows.push_back('{hdr(32'h5555_5555, 16'h5555, 8'h55, 16'h5555, 16'hAAAA,
                         40'h55_5555_5555), 1'b0, '0});
    rows.push_back('{hdr(32'hAAAA_AAAA, 16'hAAAA, 8'hAA, 16'hAAAA, 16'h5555,
                         40'hAA_AAAA_AAAA), 1'b0, '0});
    rows.push_back('{hdr(32'h5555_5555, 16'd0, PROTO_TCP, HTTP_PORT_RST, SSH_PORT_RST, 40'd0),
                     1'b0, '0});
    rows.push_back('{hdr(32'hAAAA_AAAA, 16'd20, PROTO_ICMP, 16'd0, 16'd0, 40'hFF_FFFF_FFFF),
                     1'b0, '0});
    rows.push_back('{hdr(32'h0000_0001, 16'hFFFF, PROTO_UDP, 16'd0, 16'd0, 40'd4000), 1'b0,
                     '0});
    rows.push_back('{hdr(32'h8000_0000, 16'd1, 8'h80, 16'h8000, 16'h0001, 40'h80_0000_0000),
                     1'b0, '0});
    rows.push_back('{hdr(32'h0A00_0002, 16'd60, PROTO_UDP, HTTP_PORT_RST, HTTP_PORT_RST,
                         40'h80_0000_0001), 1'b0, '0});
    foreach (rows[k]) send_header(rows[k].hdr, 0, rows[k].typed, rows[k].want);

    run_phase(FTP_PORT_RST, SSH_PORT_RST, DNS_PORT_RST, HTTP_PORT_RST, 0, 200);
    // ftp and dns share a port, so dns never wins
    run_phase(16'd0, 16'hFFFF, 16'd0, 16'd443, 77, 250);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6, 200);
    run_phase(16'd8080, 16'd0, 16'd22, 16'hFFFF, 0, 200);
    run_phase(FTP_PORT_RST, SSH_PORT_RST, DNS_PORT_RST, HTTP_PORT_RST, 77, 200);

    wait_drained();
    repeat (HOSTS + 8) @(posedge clk);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== packet_statistics_host_table_core.f =====
src/psht_pkg.sv
src/psht_ram.sv
src/psht_front.sv
src/psht_queue.sv
src/psht_back.sv
src/packet_statistics_host_table_core.sv
test/tb_packet_statistics_host_table_core.sv
